// ===== design/sql_char_style_lexer_top_defines.svh =====
// Assertion macros used by the lexer checker in sqlcl_check.sv.
`ifndef SQL_CHAR_STYLE_LEXER_TOP_DEFINES_SVH
`define SQL_CHAR_STYLE_LEXER_TOP_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define SQLCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A signal must hold its value while the output is stalled.
`define SQLCL_ASSERT_HOLD(lbl, sig, msg) \
	`SQLCL_ASSERT(lbl, (out_valid && !out_ready |=> $stable(sig)), msg)

`endif

// ===== design/sqlcl_pkg.sv =====
package sqlcl_pkg;

	// Style class of one character
	typedef enum logic [2:0] {
		STYLE_NONE     = 3'd0,
		STYLE_CONTROL  = 3'd1,
		STYLE_TYPE     = 3'd2,
		STYLE_CONST    = 3'd3,
		STYLE_COMMENT  = 3'd4,
		STYLE_NONASCII = 3'd5
	} style_t;

	// Scanner mode
	typedef enum logic [7:0] {
		MODE_PLAIN   = 8'b0000_0001,
		MODE_COMMENT = 8'b0000_0010,
		MODE_SQUOTE  = 8'b0000_0100,
		MODE_DQUOTE  = 8'b0000_1000,
		MODE_NUM     = 8'b0001_0000,
		MODE_HEX     = 8'b0010_0000,
		MODE_FRAC    = 8'b0100_0000,
		MODE_EXP     = 8'b1000_0000
	} mode_t;

	// Printable ASCII range
	localparam logic [7:0] CHAR_LOW  = 8'd32;
	localparam logic [7:0] CHAR_HIGH = 8'd126;

	// One input item
	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] next_ch;
		logic       next_valid;
		logic       line_start;
		logic       restart;
	} item_t;

	// Scanner state carried from item to item
	typedef struct packed {
		mode_t      mode;
		logic [7:0] prev_char;
		logic       escape_seen;
		logic       pair_pending;
		style_t     pair_class;
		logic       sign_allowed;
	} lex_state_t;

endpackage

// ===== design/sqlcl_in_if.sv =====
interface sqlcl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic [7:0] next_ch;
	logic       next_valid;
	logic       line_start;
	logic       restart;

	modport source (output valid, ch, next_ch, next_valid, line_start, restart, input ready);
	modport sink (input valid, ch, next_ch, next_valid, line_start, restart, output ready);
endinterface

// ===== design/sqlcl_out_if.sv =====
interface sqlcl_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] style;

	modport source (output valid, style, input ready);
	modport sink (input valid, style, output ready);
endinterface

// ===== design/sqlcl_in_reg.sv =====
module sqlcl_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sqlcl_pkg::item_t in_item,
	input  logic           advance,
	output logic           valid_s1,
	output sqlcl_pkg::item_t item_s1
);
	import sqlcl_pkg::*;

	// Accept when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the payload of the accepted item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end
endmodule

// ===== design/sqlcl_lex.sv =====
module sqlcl_lex (
	input  sqlcl_pkg::item_t     it,
	input  sqlcl_pkg::lex_state_t st,
	output sqlcl_pkg::lex_state_t nx,
	output sqlcl_pkg::style_t     style
);
	import sqlcl_pkg::*;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
			|| (c == "_");
	endfunction

	lex_state_t s;
	logic       done;
	logic [7:0] c;
	logic [7:0] n;
	logic       nv;
	logic       ls;
	logic [7:0] quote;
	logic [7:0] c1;
	logic [7:0] c0;
	logic       esc_in;
	logic       str_end;
	logic       type_pair;
	logic       ctrl_pair;

	assign c  = it.ch;
	assign n  = it.next_ch;
	assign nv = it.next_valid;
	assign ls = it.line_start;

	// String close test: at column zero the character has no predecessor.
	// The string branch only runs when neither restart nor a new line left plain mode,
	// so the quote follows the held mode and the escape flag clears on either.
	assign quote   = (st.mode == MODE_SQUOTE) ? 8'("'") : 8'("\"");
	assign esc_in  = st.escape_seen && !it.restart && !ls;
	assign c1      = ls ? c : st.prev_char;
	assign c0      = ls ? 8'd0 : c;
	assign str_end = ((c1 == quote) && (c0 == 8'd0))
		|| ((c0 == quote) && ((c1 != "\\") || esc_in));

	// Two-character operators
	assign type_pair = nv && (((c == ":") && (n == ":")) || ((c == "-") && (n == ">")));
	assign ctrl_pair = nv && (((c == "=") && (n == "=")) || ((c == "&") && (n == "&"))
		|| ((c == "|") && (n == "|")) || ((c == "|") && (n == "="))
		|| ((c == "&") && (n == "=")) || ((c == "!") && (n == "="))
		|| ((c == "+") && (n == "=")) || ((c == "-") && (n == "=")));

	always_comb begin
		s     = st;
		style = STYLE_NONE;
		done  = 1'b0;

		// Restart drops into plain mode
		if (it.restart) begin
			s.mode         = MODE_PLAIN;
			s.escape_seen  = 1'b0;
			s.pair_pending = 1'b0;
			s.pair_class   = STYLE_NONE;
			s.sign_allowed = 1'b0;
		end

		// New line ends comments and numbers, strings stay open
		if (ls) begin
			if ((s.mode != MODE_SQUOTE) && (s.mode != MODE_DQUOTE)) begin
				s.mode = MODE_PLAIN;
			end
			s.escape_seen  = 1'b0;
			s.pair_pending = 1'b0;
			s.sign_allowed = 1'b0;
		end

		if (s.pair_pending) begin
			// Second half of an operator pair
			style          = s.pair_class;
			s.pair_pending = 1'b0;
			s.pair_class   = STYLE_NONE;
			done           = 1'b1;
		end else begin
			case (s.mode)
				MODE_COMMENT: begin
					style = STYLE_COMMENT;
					done  = 1'b1;
				end
				MODE_SQUOTE, MODE_DQUOTE: begin
					if (str_end) begin
						s.mode        = MODE_PLAIN;
						s.escape_seen = 1'b0;
					end else begin
						s.escape_seen = (c1 == "\\") && (c0 == "\\");
					end
					style = STYLE_CONST;
					done  = 1'b1;
				end
				MODE_NUM, MODE_FRAC: begin
					if (is_digit(c)) begin
						style = STYLE_CONST;
						done  = 1'b1;
					end else if ((s.mode == MODE_NUM) && (c == ".")) begin
						s.mode = MODE_FRAC;
						style  = STYLE_CONST;
						done   = 1'b1;
					end else if ((c == "e") || (c == "E")) begin
						s.mode         = MODE_EXP;
						s.sign_allowed = 1'b1;
						style          = STYLE_CONST;
						done           = 1'b1;
					end else begin
						s.mode = MODE_PLAIN;
					end
				end
				MODE_HEX: begin
					if (is_xdigit(c)) begin
						style = STYLE_CONST;
						done  = 1'b1;
					end else begin
						s.mode = MODE_PLAIN;
					end
				end
				MODE_EXP: begin
					if ((s.sign_allowed && ((c == "+") || (c == "-"))) || is_digit(c)) begin
						style = STYLE_CONST;
						done  = 1'b1;
					end else begin
						s.mode = MODE_PLAIN;
					end
					s.sign_allowed = 1'b0;
				end
				default: begin
					s.mode = MODE_PLAIN;
				end
			endcase
		end

		// Plain-mode scan
		if (!done) begin
			if (nv && (c == "-") && (n == "-")) begin
				s.mode = MODE_COMMENT;
				style  = STYLE_COMMENT;
			end else if (c == "'") begin
				s.mode        = MODE_SQUOTE;
				s.escape_seen = 1'b0;
				style         = STYLE_CONST;
			end else if (c == "\"") begin
				s.mode        = MODE_DQUOTE;
				s.escape_seen = 1'b0;
				style         = STYLE_CONST;
			end else if (!ls && !is_ident(st.prev_char) && is_digit(c)) begin
				if ((c == "0") && nv && (n == "x")) begin
					s.mode         = MODE_HEX;
					s.pair_pending = 1'b1;
					s.pair_class   = STYLE_CONST;
				end else begin
					s.mode = MODE_NUM;
				end
				style = STYLE_CONST;
			end else if (type_pair) begin
				s.pair_pending = 1'b1;
				s.pair_class   = STYLE_TYPE;
				style          = STYLE_TYPE;
			end else if (ctrl_pair) begin
				s.pair_pending = 1'b1;
				s.pair_class   = STYLE_CONTROL;
				style          = STYLE_CONTROL;
			end else begin
				case (c)
					"&", ".", "*", "[", "]": style = STYLE_TYPE;
					"~", "=", "^", ":", "%", "+", "-", "<", ">", "!", "?", "(", ")",
					"{", "}", ",", ";", "/", "|": style = STYLE_CONTROL;
					default: begin
						style = ((c < CHAR_LOW) || (c > CHAR_HIGH)) ? STYLE_NONASCII
							: STYLE_NONE;
					end
				endcase
			end
		end

		s.prev_char = c;
		nx          = s;
	end
endmodule

// ===== design/sql_char_style_lexer_top.sv =====
// Channel | Dir | Payload                                        | Handshake
// chars   | in  | ch, next_ch, next_valid, line_start, restart   | valid/ready
// styles  | out | style                                          | valid/ready
//
// One item per cycle while the output is not stalled; each item is held in
// the input register, then in the output register. The scanner state lives
// in one register set updated as each item leaves the input register.
// arst_n clears the scanner to plain mode and empties both registers.
// A stalled result holds in the output register while one more item waits.
module sql_char_style_lexer_top (
	input logic clk,
	input logic arst_n,
	sqlcl_in_if.sink    chars,
	sqlcl_out_if.source styles
);
	import sqlcl_pkg::*;

	item_t      in_item;
	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	lex_state_t state_q;
	lex_state_t state_nx;
	style_t     style_nx;
	logic       out_valid_q;
	style_t     style_q;

	assign in_item = '{ch: chars.ch, next_ch: chars.next_ch, next_valid: chars.next_valid,
		line_start: chars.line_start, restart: chars.restart};

	// Move the held item into the output register when there is room
	assign advance = valid_s1 && (!out_valid_q || styles.ready);

	sqlcl_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sqlcl_lex u_lex (
		.it    (item_s1),
		.st    (state_q),
		.nx    (state_nx),
		.style (style_nx)
	);

	// Advance the scanner state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_PLAIN, prev_char: 8'd0, escape_seen: 1'b0,
				pair_pending: 1'b0, pair_class: STYLE_NONE, sign_allowed: 1'b0};
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (styles.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			style_q <= style_nx;
		end
	end

	assign styles.valid = out_valid_q;
	assign styles.style = style_q;
endmodule

// ===== design/sqlcl_check.sv =====
`include "sql_char_style_lexer_top_defines.svh"

module sqlcl_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] style
);
	`SQLCL_ASSERT_HOLD(a_valid_hold, out_valid, "result valid dropped while stalled")
	`SQLCL_ASSERT_HOLD(a_style_hold, style, "result style changed while stalled")
	`SQLCL_ASSERT(a_rise_needs_item, ($rose(out_valid) |-> $past(in_valid && in_ready, 2)), "result appeared without an accepted item")
	`SQLCL_ASSERT(a_ready_when_empty, (!out_valid |-> in_ready), "input stalled with empty output")
endmodule

bind sql_char_style_lexer_top sqlcl_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.out_valid (styles.valid),
	.out_ready (styles.ready),
	.style     (styles.style)
);
